[rtl/keyword_command_line_parser_defines.svh]
// assertion macros shared by the keyword command line parser rtl
// depends on nothing; included by files that carry concurrent assertions
`ifndef KEYWORD_COMMAND_LINE_PARSER_DEFINES_SVH
`define KEYWORD_COMMAND_LINE_PARSER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define KCLP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kclp assertion failed");

// next-cycle implication, checked outside reset
`define KCLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kclp assertion failed");

`endif

[rtl/kclp_pkg.sv]
// types, character constants and keyword tables for the command line parser
// no dependencies; used by keyword_command_line_parser
package kclp_pkg;

  typedef enum logic [1:0] {
    PH_CMD = 2'd0,
    PH_TRG = 2'd1,
    PH_DET = 2'd2,
    PH_VAL = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    LP_IDLE = 2'd0,
    LP_ONE  = 2'd1,
    LP_TWO  = 2'd2
  } letter_pos_e;

  typedef enum logic [1:0] {
    NUM_NONE = 2'd0,
    NUM_DEC  = 2'd1,
    NUM_HEX  = 2'd2
  } num_mode_e;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  localparam logic [3:0] DEC_MAX_DIGITS = 4'd10;
  localparam logic [3:0] HEX_MAX_DIGITS = 4'd8;

  localparam logic HEX_ENABLE_RESET = 1'b1;

  localparam int NumCmdWords = 12;
  localparam int NumTrgWords = 11;
  localparam int NumDetWords = 21;

  localparam logic [23:0] CMD_WORDS [NumCmdWords] = '{
    "REG", "PIN", "SET", "SAV", "DEF", "INF",
    "VER", "HWI", "RST", "LDE", "STE", "%%%"
  };

  localparam logic [23:0] TRG_WORDS [NumTrgWords] = '{
    "LMK", "LMX", "DAC", "LED", "VCO", "GPS",
    "IOS", "STS", "ADF", "JTG", "PLD"
  };

  localparam logic [23:0] DET_WORDS [NumDetWords] = '{
    "ENB", "GOE", "SYN", "OSC", "OUT", "PRT", "MIN",
    "MAX", "KBT", "DIV", "AUT", "D12", "R00", "R01",
    "R02", "R03", "LCK", "RST", "RUN", "SDR", "SIR"
  };

  function automatic logic is_end_byte(input logic [7:0] b);
    return (b == CH_NUL) || (b == CH_CR) || (b == CH_LF);
  endfunction

  // parallel compare, lowest position wins; miss gives table size plus one
  function automatic logic [3:0] cmd_lookup(input logic [23:0] w);
    logic [3:0] code;
    code = 4'(NumCmdWords + 1);
    for (int k = NumCmdWords - 1; k >= 0; k--) begin
      if (CMD_WORDS[k] == w) code = 4'(k + 1);
    end
    return code;
  endfunction

  function automatic logic [3:0] trg_lookup(input logic [23:0] w);
    logic [3:0] code;
    code = 4'(NumTrgWords + 1);
    for (int k = NumTrgWords - 1; k >= 0; k--) begin
      if (TRG_WORDS[k] == w) code = 4'(k + 1);
    end
    return code;
  endfunction

  function automatic logic [4:0] det_lookup(input logic [23:0] w);
    logic [4:0] code;
    code = 5'(NumDetWords + 1);
    for (int k = NumDetWords - 1; k >= 0; k--) begin
      if (DET_WORDS[k] == w) code = 5'(k + 1);
    end
    return code;
  endfunction

endpackage

[rtl/keyword_command_line_parser.sv]
// keyword command line parser: byte-wise parser for CMD,TARGET,DETAIL,VALUE lines
// depends on kclp_pkg and keyword_command_line_parser_defines.svh
//
// usage
//   input channel: one text byte per beat on rx_byte_i, in_valid_i / in_stall_o.
//   output channel: one result beat per command end (status, three word codes,
//   value), out_valid_o / out_stall_i. cfg channel: cfg_valid_i / cfg_ready_o
//   writes hex_enable; ready is always high, write only while the block is idle.
// timing
//   a byte is held in an input register until it is parsed by a single pass
//   of combinational logic (keyword compare, digit accumulate) into the state
//   and result registers. a terminating byte loads the result register when
//   it is parsed, which raises out_valid_o. one byte per cycle is taken for as
//   long as the output register is free or being emptied in the same cycle.
// stall
//   while the receiver stalls a pending result, the byte in the input register
//   is not parsed, whether or not it ends a command; in_stall_o is high until
//   the result is taken. with the input register empty one more byte is taken.
// reset
//   rst_ni clears all parser state, empties both registers and sets hex_enable.
`include "keyword_command_line_parser_defines.svh"

module keyword_command_line_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [3:0]  cmd_code_o,
  output logic [3:0]  target_code_o,
  output logic [4:0]  detail_code_o,
  output logic [31:0] value_o,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_hex_enable_i
);

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;

  // configuration
  logic hex_en_q;

  // parser state
  kclp_pkg::phase_e      phase_q,   phase_d;
  kclp_pkg::letter_pos_e lpos_q,    lpos_d;
  kclp_pkg::num_mode_e   nmode_q,   nmode_d;
  logic [7:0]            first_q,   first_d;
  logic [7:0]            second_q,  second_d;
  logic                  early_q,   early_d;
  logic [3:0]            cmd_q,     cmd_d;
  logic [3:0]            trg_q,     trg_d;
  logic [4:0]            det_q,     det_d;
  logic [31:0]           acc_q,     acc_d;
  logic [3:0]            dcnt_q,    dcnt_d;

  // result register
  logic        out_vld_q;
  logic        res_status_q;
  logic [3:0]  res_cmd_q;
  logic [3:0]  res_trg_q;
  logic [4:0]  res_det_q;
  logic [31:0] res_val_q;

  logic        advance;   // byte in the input register is parsed this cycle
  logic        in_take;   // input beat accepted
  logic        emit;      // parsed byte ends a command
  logic        emit_status;
  logic [7:0]  b;
  logic        dec_ok;
  logic [3:0]  dec_val;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [23:0] word;

  // a result may be written when the output register is empty or draining
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign b    = in_byte_q;
  assign word = {first_q, second_q, b};

  // digit decode
  always_comb begin
    dec_ok  = (b >= kclp_pkg::CH_ZERO) && (b <= kclp_pkg::CH_NINE);
    dec_val = 4'(b - kclp_pkg::CH_ZERO);
    hex_ok  = 1'b1;
    if (dec_ok) begin
      hex_val = dec_val;
    end else if ((b >= kclp_pkg::CH_LC_A) && (b <= kclp_pkg::CH_LC_F)) begin
      hex_val = 4'(b - kclp_pkg::CH_LC_A + 8'd10);
    end else if ((b >= kclp_pkg::CH_UC_A) && (b <= kclp_pkg::CH_UC_F)) begin
      hex_val = 4'(b - kclp_pkg::CH_UC_A + 8'd10);
    end else begin
      hex_ok  = 1'b0;
      hex_val = 4'd0;
    end
  end

  // single-pass parse of the held byte
  always_comb begin
    phase_d     = phase_q;
    lpos_d      = lpos_q;
    nmode_d     = nmode_q;
    first_d     = first_q;
    second_d    = second_q;
    early_d     = early_q;
    cmd_d       = cmd_q;
    trg_d       = trg_q;
    det_d       = det_q;
    acc_d       = acc_q;
    dcnt_d      = dcnt_q;
    emit        = 1'b0;
    emit_status = kclp_pkg::STATUS_OK;

    unique case (nmode_q)
      kclp_pkg::NUM_DEC: begin
        if ((dcnt_q < kclp_pkg::DEC_MAX_DIGITS) && dec_ok) begin
          // acc * 10 as two shifts
          acc_d  = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + {28'd0, dec_val};
          dcnt_d = dcnt_q + 4'd1;
        end else begin
          emit        = 1'b1;
          emit_status = kclp_pkg::is_end_byte(b) ? kclp_pkg::STATUS_OK
                                                 : kclp_pkg::STATUS_ERR;
        end
      end
      kclp_pkg::NUM_HEX: begin
        if ((dcnt_q < kclp_pkg::HEX_MAX_DIGITS) && hex_ok) begin
          acc_d  = {acc_q[27:0], hex_val};
          dcnt_d = dcnt_q + 4'd1;
        end else begin
          emit        = 1'b1;
          emit_status = kclp_pkg::is_end_byte(b) ? kclp_pkg::STATUS_OK
                                                 : kclp_pkg::STATUS_ERR;
        end
      end
      default: begin
        priority if (lpos_q == kclp_pkg::LP_ONE) begin
          second_d = b;
          early_d  = kclp_pkg::is_end_byte(b);
          lpos_d   = kclp_pkg::LP_TWO;
        end else if (lpos_q == kclp_pkg::LP_TWO) begin
          // third letter: word cut short by a terminator is an error
          if (early_q || kclp_pkg::is_end_byte(b)) begin
            emit        = 1'b1;
            emit_status = kclp_pkg::STATUS_ERR;
          end else begin
            unique case (phase_q)
              kclp_pkg::PH_CMD: cmd_d = kclp_pkg::cmd_lookup(word);
              kclp_pkg::PH_TRG: trg_d = kclp_pkg::trg_lookup(word);
              default:          det_d = kclp_pkg::det_lookup(word);
            endcase
            lpos_d = kclp_pkg::LP_IDLE;
          end
        end else if (b == kclp_pkg::CH_SPACE) begin
          // leading space skipped
        end else if (b == kclp_pkg::CH_COMMA) begin
          if (phase_q == kclp_pkg::PH_VAL) begin
            emit        = 1'b1;
            emit_status = kclp_pkg::STATUS_ERR;
          end else begin
            phase_d = kclp_pkg::phase_e'(phase_q + 2'd1);
          end
        end else if (kclp_pkg::is_end_byte(b)) begin
          emit        = 1'b1;
          emit_status = kclp_pkg::STATUS_OK;
        end else if (phase_q != kclp_pkg::PH_VAL) begin
          first_d = b;
          lpos_d  = kclp_pkg::LP_ONE;
        end else if (((b == kclp_pkg::CH_LC_X) || (b == kclp_pkg::CH_UC_X))
                     && hex_en_q) begin
          nmode_d = kclp_pkg::NUM_HEX;
          dcnt_d  = 4'd0;
          acc_d   = 32'd0;
        end else if (dec_ok) begin
          nmode_d = kclp_pkg::NUM_DEC;
          dcnt_d  = 4'd1;
          acc_d   = {28'd0, dec_val};
        end else begin
          emit        = 1'b1;
          emit_status = kclp_pkg::STATUS_ERR;
        end
      end
    endcase

    // every command end returns the parser to its start condition
    if (emit) begin
      phase_d  = kclp_pkg::PH_CMD;
      lpos_d   = kclp_pkg::LP_IDLE;
      nmode_d  = kclp_pkg::NUM_NONE;
      first_d  = 8'd0;
      second_d = 8'd0;
      early_d  = 1'b0;
      cmd_d    = 4'd0;
      trg_d    = 4'd0;
      det_d    = 5'd0;
      acc_d    = 32'd0;
      dcnt_d   = 4'd0;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hex_en_q <= kclp_pkg::HEX_ENABLE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      hex_en_q <= cfg_hex_enable_i;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= kclp_pkg::PH_CMD;
      lpos_q   <= kclp_pkg::LP_IDLE;
      nmode_q  <= kclp_pkg::NUM_NONE;
      first_q  <= 8'd0;
      second_q <= 8'd0;
      early_q  <= 1'b0;
      cmd_q    <= 4'd0;
      trg_q    <= 4'd0;
      det_q    <= 5'd0;
      acc_q    <= 32'd0;
      dcnt_q   <= 4'd0;
    end else if (advance) begin
      phase_q  <= phase_d;
      lpos_q   <= lpos_d;
      nmode_q  <= nmode_d;
      first_q  <= first_d;
      second_q <= second_d;
      early_q  <= early_d;
      cmd_q    <= cmd_d;
      trg_q    <= trg_d;
      det_q    <= det_d;
      acc_q    <= acc_d;
      dcnt_q   <= dcnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && emit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      res_status_q <= emit_status;
      res_cmd_q    <= cmd_q;
      res_trg_q    <= trg_q;
      res_det_q    <= det_q;
      res_val_q    <= acc_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = res_status_q;
  assign cmd_code_o    = res_cmd_q;
  assign target_code_o = res_trg_q;
  assign detail_code_o = res_det_q;
  assign value_o       = res_val_q;

  // a number is only ever collected in the value field, never mid-word
  `KCLP_ASSERT_NOW(a_num_in_value, clk_i, rst_ni, nmode_q != kclp_pkg::NUM_NONE,
    (phase_q == kclp_pkg::PH_VAL) && (lpos_q == kclp_pkg::LP_IDLE))

  // letters are only held in a word field
  `KCLP_ASSERT_NOW(a_word_field, clk_i, rst_ni, lpos_q != kclp_pkg::LP_IDLE,
    phase_q != kclp_pkg::PH_VAL)

  // digit count bounded by the mode limit
  `KCLP_ASSERT_NOW(a_dcnt_bound, clk_i, rst_ni, 1'b1,
    ((nmode_q == kclp_pkg::NUM_HEX) && (dcnt_q <= kclp_pkg::HEX_MAX_DIGITS)) ||
    ((nmode_q != kclp_pkg::NUM_HEX) && (dcnt_q <= kclp_pkg::DEC_MAX_DIGITS)))

  // a command end loads a result and restarts the parser
  `KCLP_ASSERT_NEXT(a_emit_restart, clk_i, rst_ni, advance && emit,
    out_vld_q && (phase_q == kclp_pkg::PH_CMD) && (lpos_q == kclp_pkg::LP_IDLE) &&
    (nmode_q == kclp_pkg::NUM_NONE) && (acc_q == 32'd0))

endmodule
